### rtl/mprc_pkg.sv
// Shared types and constants for the marked position range counter.
// Depends on nothing; every other file of the block but mprc_ram uses it.
`default_nettype none
package mprc_pkg;

   localparam int MAX_POSITIONS = 1024;
   localparam int FIELD_W       = 11;
   localparam int KIND_W        = 2;
   localparam int NODE_COUNT    = 2 * MAX_POSITIONS;
   localparam int NODE_W        = $clog2(NODE_COUNT);
   localparam int IDX_W         = NODE_W + 1;
   localparam int CNT_W         = $clog2(MAX_POSITIONS) + 1;
   localparam int WIDE_W        = (IDX_W > FIELD_W) ? IDX_W : FIELD_W;

   localparam logic [FIELD_W-1:0] SIZE_RESET = FIELD_W'(1024);

   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MARK  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COUNT = 2'd2;

   typedef struct packed {
      logic accept;
      logic clear_init;
      logic clear_step;
      logic mark_read;
      logic mark_step;
      logic count_step;
      logic rsp_load;
   } mprc_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic pos_ok;
      logic range_ok;
      logic leaf_marked;
      logic at_root;
      logic walk_done;
      logic rsp_free;
   } mprc_stat_type;

endpackage
`default_nettype wire

### rtl/mprc_req_if.sv
// Request channel: valid/ready handshake carrying one operation per beat.
// Depends on mprc_pkg for the field widths.
`default_nettype none
interface mprc_req_if;
   logic                          valid;
   logic                          ready;
   logic [mprc_pkg::KIND_W-1:0]   kind;
   logic [mprc_pkg::FIELD_W-1:0]  range_low;
   logic [mprc_pkg::FIELD_W-1:0]  range_high;

   modport source (output valid, output kind, output range_low, output range_high,
                   input ready);
   modport sink   (input valid, input kind, input range_low, input range_high,
                   output ready);
endinterface
`default_nettype wire

### rtl/mprc_rsp_if.sv
// Response channel: valid/ready handshake carrying one count per beat.
// Depends on mprc_pkg for the field width.
`default_nettype none
interface mprc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mprc_pkg::FIELD_W-1:0]  marked_count;

   modport source (output valid, output marked_count, input ready);
   modport sink   (input valid, input marked_count, output ready);
endinterface
`default_nettype wire

### rtl/mprc_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// Stand-alone; used for the node store of the tree.
`default_nettype none
module mprc_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_a_en,
   input  logic [ADDR_W-1:0] rd_a_addr,
   output logic [WIDTH-1:0]  rd_a_data,
   input  logic              rd_b_en,
   input  logic [ADDR_W-1:0] rd_b_addr,
   output logic [WIDTH-1:0]  rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_data <= mem_ff[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_data <= mem_ff[rd_b_addr];
      end
   end

endmodule
`default_nettype wire

### rtl/mprc_datapath.sv
// Datapath: size register, range clipping, tree walk indices, node store,
// running sum and response register. Depends on mprc_pkg and mprc_ram.
`default_nettype none
module mprc_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mprc_pkg::FIELD_W-1:0]  req_range_low,
   input  logic [mprc_pkg::FIELD_W-1:0]  req_range_high,
   input  logic                          csr_write_enable,
   input  logic [mprc_pkg::FIELD_W-1:0]  csr_write_data,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [mprc_pkg::FIELD_W-1:0]  rsp_marked_count,
   input  mprc_pkg::mprc_cmd_type        cmd,
   output mprc_pkg::mprc_stat_type       stat
);
   import mprc_pkg::*;

   logic [FIELD_W-1:0] size_ff, size_in;
   logic [NODE_W-1:0]  clr_ff, clr_in;
   logic [IDX_W-1:0]   l_ff, l_in, r_ff, r_in;
   logic               pos_ok_ff, pos_ok_in, range_ok_ff, range_ok_in;
   logic               take_a_ff, take_a_in, take_b_ff, take_b_in;
   logic [CNT_W-1:0]   sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_data_ff, rsp_data_in;

   logic [WIDE_W-1:0]  n_w, lo_w, hi_w, lo_c, hi_c;
   logic               wr_en, rd_a_en, rd_b_en;
   logic [NODE_W-1:0]  wr_addr, rd_a_addr, rd_b_addr;
   logic [CNT_W-1:0]   wr_data, rd_a_data, rd_b_data, add_a, add_b;

   // clip the requested range to the positions in use
   always_comb begin
      if (size_ff == '0) begin
         n_w = WIDE_W'(1);
      end else if (WIDE_W'(size_ff) > WIDE_W'(MAX_POSITIONS)) begin
         n_w = WIDE_W'(MAX_POSITIONS);
      end else begin
         n_w = WIDE_W'(size_ff);
      end
      lo_w = WIDE_W'(req_range_low);
      hi_w = WIDE_W'(req_range_high);
      lo_c = (lo_w == '0) ? WIDE_W'(1) : lo_w;
      hi_c = (hi_w > n_w) ? n_w : hi_w;
   end

   always_comb begin
      size_in     = csr_write_enable ? csr_write_data : size_ff;
      l_in        = l_ff;
      r_in        = r_ff;
      pos_ok_in   = pos_ok_ff;
      range_ok_in = range_ok_ff;
      clr_in      = clr_ff;
      take_a_in   = 1'b0;
      take_b_in   = 1'b0;
      if (cmd.accept) begin
         l_in        = IDX_W'(WIDE_W'(MAX_POSITIONS) + lo_c - WIDE_W'(1));
         r_in        = IDX_W'(WIDE_W'(MAX_POSITIONS) + hi_c);
         pos_ok_in   = (lo_w != '0) && (lo_w <= n_w);
         range_ok_in = (lo_c <= hi_c);
      end else if (cmd.mark_step) begin
         l_in = l_ff >> 1;
      end else if (cmd.count_step) begin
         l_in      = (l_ff >> 1) + IDX_W'(l_ff[0]);
         r_in      = r_ff >> 1;
         take_a_in = l_ff[0];
         take_b_in = r_ff[0];
      end
      if (cmd.clear_init) begin
         clr_in = '0;
      end else if (cmd.clear_step) begin
         clr_in = clr_ff + NODE_W'(1);
      end
   end

   // node store access
   always_comb begin
      wr_en     = cmd.clear_step | cmd.mark_step;
      wr_addr   = cmd.clear_step ? clr_ff : l_ff[NODE_W-1:0];
      wr_data   = cmd.clear_step ? '0 : rd_a_data + CNT_W'(1);
      rd_a_en   = cmd.mark_read | cmd.mark_step | (cmd.count_step & l_ff[0]);
      rd_a_addr = cmd.mark_step ? NODE_W'(l_ff >> 1) : l_ff[NODE_W-1:0];
      rd_b_en   = cmd.count_step & r_ff[0];
      rd_b_addr = NODE_W'(r_ff - IDX_W'(1));
   end

   always_comb begin
      add_a  = take_a_ff ? rd_a_data : '0;
      add_b  = take_b_ff ? rd_b_data : '0;
      sum_in = cmd.accept ? '0 : CNT_W'(sum_ff + add_a + add_b);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = FIELD_W'(sum_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_RESET;
         clr_ff       <= '0;
         take_a_ff    <= 1'b0;
         take_b_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         clr_ff       <= clr_in;
         take_a_ff    <= take_a_in;
         take_b_ff    <= take_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      l_ff        <= l_in;
      r_ff        <= r_in;
      pos_ok_ff   <= pos_ok_in;
      range_ok_ff <= range_ok_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   mprc_ram #(
      .WIDTH (CNT_W),
      .DEPTH (NODE_COUNT)
   ) u_nodes (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_en   (rd_a_en),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a_data),
      .rd_b_en   (rd_b_en),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (rd_b_data)
   );

   always_comb begin
      stat.clear_last  = (clr_ff == NODE_W'(NODE_COUNT - 1));
      stat.pos_ok      = pos_ok_ff;
      stat.range_ok    = range_ok_ff;
      stat.leaf_marked = (rd_a_data != '0);
      stat.at_root     = (l_ff == IDX_W'(1));
      stat.walk_done   = !(l_ff < r_ff);
      stat.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_marked_count = rsp_data_ff;

endmodule
`default_nettype wire

### rtl/mprc_ctrl.sv
// Controller: one-hot state machine that sequences clear sweeps, mark walks
// and count walks. Depends on mprc_pkg; drives mprc_datapath by commands.
`default_nettype none
module mprc_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [mprc_pkg::KIND_W-1:0]  req_kind,
   output logic                         req_ready,
   input  logic                         csr_write_enable,
   output mprc_pkg::mprc_cmd_type       cmd,
   input  mprc_pkg::mprc_stat_type      stat
);
   import mprc_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE        = 8'b0000_0001,
      ST_CLEAR       = 8'b0000_0010,
      ST_MARK_CHECK  = 8'b0000_0100,
      ST_MARK_LEAF   = 8'b0000_1000,
      ST_MARK_UP     = 8'b0001_0000,
      ST_COUNT_CHECK = 8'b0010_0000,
      ST_COUNT_WALK  = 8'b0100_0000,
      ST_COUNT_DONE  = 8'b1000_0000
   } mprc_state_type;

   mprc_state_type state_ff, state_in;
   logic           accept;

   assign req_ready = (state_ff == ST_IDLE) && !csr_write_enable;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.accept     = accept;
      cmd.clear_init = csr_write_enable;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_CLEAR: begin
                     cmd.clear_init = 1'b1;
                     state_in       = ST_CLEAR;
                  end
                  KIND_MARK:  state_in = ST_MARK_CHECK;
                  KIND_COUNT: state_in = ST_COUNT_CHECK;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.clear_step = !csr_write_enable;
            if (stat.clear_last && !csr_write_enable) begin
               state_in = ST_IDLE;
            end
         end
         ST_MARK_CHECK: begin
            if (stat.pos_ok) begin
               cmd.mark_read = 1'b1;
               state_in      = ST_MARK_LEAF;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MARK_LEAF: begin
            if (stat.leaf_marked) begin
               state_in = ST_IDLE;
            end else begin
               cmd.mark_step = 1'b1;
               state_in      = ST_MARK_UP;
            end
         end
         ST_MARK_UP: begin
            cmd.mark_step = 1'b1;
            if (stat.at_root) begin
               state_in = ST_IDLE;
            end
         end
         ST_COUNT_CHECK: begin
            state_in = stat.range_ok ? ST_COUNT_WALK : ST_COUNT_DONE;
         end
         ST_COUNT_WALK: begin
            if (stat.walk_done) begin
               state_in = ST_COUNT_DONE;
            end else begin
               cmd.count_step = 1'b1;
            end
         end
         ST_COUNT_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // a size write restarts the clear sweep
      if (csr_write_enable) begin
         state_in = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### rtl/marked_position_range_counter.sv
// Marked position range counter: top level joining controller and datapath.
// Depends on mprc_pkg, mprc_req_if, mprc_rsp_if, mprc_ctrl, mprc_datapath.
//
// Request channel (req_ch): one beat carries kind, range_low, range_high.
//   Clear all marks, mark one position, or count marks in a range.
// Response channel (rsp_ch): one beat with marked_count for each count
//   request; clear and mark give no beat.
// Register size_in_use (csr_write_enable / csr_write_data) sets the positions
// in use; writing it also clears all marks.
// One item is taken at a time, with ready high only while idle:
//   mark: one node store read and write per tree level
//     (leaf plus log2(MAX_POSITIONS) ancestors).
//   count: both ends of the range walked one level a cycle over the two
//     read ports of the node store.
//   clear: one node store entry zeroed per cycle, restarted by a size write.
// After reset, and after each size write, the same clearing pass runs before
// the first request is taken.
// The response sits in an output register; a new request is taken while it
// waits, and a further count holds at its end until the receiver takes it.
`default_nettype none
module marked_position_range_counter (
   input  logic                          clock,
   input  logic                          reset,
   mprc_req_if.sink                      req_ch,
   mprc_rsp_if.source                    rsp_ch,
   input  logic                          csr_write_enable,
   input  logic [mprc_pkg::FIELD_W-1:0]  csr_write_data
);
   import mprc_pkg::*;

   mprc_cmd_type  cmd;
   mprc_stat_type stat;

   mprc_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_kind         (req_ch.kind),
      .req_ready        (req_ch.ready),
      .csr_write_enable (csr_write_enable),
      .cmd              (cmd),
      .stat             (stat)
   );

   mprc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_range_low    (req_ch.range_low),
      .req_range_high   (req_ch.range_high),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_marked_count (rsp_ch.marked_count),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule
`default_nettype wire
